@@ hdl/fqs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the FIFO queue with linear search.
// No dependencies; every other file of the block imports this package.
package fqs_pkg;

    // Default ring depth
    localparam int FQS_DEPTH = 16;

    // Fixed field widths of the channels
    localparam int OP_W  = 2;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int POS_W = 4;
    localparam int OCC_W = 5;

    // Requested operation
    typedef enum logic [OP_W-1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_SEARCH = 2'd3
    } t_op;

    // Result status
    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_SCAN = 2'd2,
        S_DONE = 2'd3
    } t_state;

endpackage

@@ hdl/fqs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on fqs_pkg for the field widths.
interface fqs_in_if import fqs_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface fqs_out_if import fqs_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] item;
    logic [POS_W-1:0]        position;
    logic [OCC_W-1:0]        occupancy;
    logic                    is_empty;

    modport source (output valid, output status, output item, output position,
                    output occupancy, output is_empty, input ready);
    modport sink   (input valid, input status, input item, input position,
                    input occupancy, input is_empty, output ready);
endinterface

@@ hdl/fqs_ram.sv @@
`timescale 1ns / 1ps
// Entry storage: one write port, one read port, registered read data.
// Depends on fqs_pkg for the word width.
module fqs_ram import fqs_pkg::*; #(
    parameter int  DEPTH = FQS_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [VAL_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [VAL_W-1:0]  o_rdata
);

    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fqs_ctrl.sv @@
`timescale 1ns / 1ps
// Queue sequencer: pointers, count, search scan and the response register.
// Depends on fqs_pkg and the channel interfaces; drives the fqs_ram ports.
module fqs_ctrl import fqs_pkg::*; #(
    parameter int  DEPTH = FQS_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    fqs_in_if.sink           i_req,
    fqs_out_if.source        o_rsp,
    output logic             o_mem_we,
    output logic [PTR_W-1:0] o_mem_waddr,
    output logic [VAL_W-1:0] o_mem_wdata,
    output logic [PTR_W-1:0] o_mem_raddr,
    input  logic [VAL_W-1:0] i_mem_rdata
);

    // Ring pointer increment with wrap at DEPTH-1
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    // Control state
    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // Working and response payload
    t_op              r_op, n_op;
    t_status          r_status, n_status;
    logic [VAL_W-1:0] r_item, n_item;
    logic [PTR_W-1:0] r_pos, n_pos;
    logic [VAL_W-1:0] r_key, n_key;
    logic [PTR_W-1:0] r_idx, n_idx;
    logic [PTR_W-1:0] r_scan_addr, n_scan_addr;
    t_status          r_out_status, n_out_status;
    logic [VAL_W-1:0] r_out_item, n_out_item;
    logic [POS_W-1:0] r_out_pos, n_out_pos;
    logic [OCC_W-1:0] r_out_occ, n_out_occ;
    logic             r_out_empty, n_out_empty;

    // Next state and memory access
    always_comb begin
        n_state      = r_state;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_count      = r_count;
        n_op         = r_op;
        n_status     = r_status;
        n_item       = r_item;
        n_pos        = r_pos;
        n_key        = r_key;
        n_idx        = r_idx;
        n_scan_addr  = r_scan_addr;
        n_out_status = r_out_status;
        n_out_item   = r_out_item;
        n_out_pos    = r_out_pos;
        n_out_occ    = r_out_occ;
        n_out_empty  = r_out_empty;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        o_mem_we     = 1'b0;
        o_mem_raddr  = (r_state == S_SCAN) ? ptr_next(r_scan_addr) : r_rp;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op        = t_op'(i_req.operation);
                    n_key       = i_req.value;
                    n_status    = ST_OK;
                    n_item      = '0;
                    n_pos       = '0;
                    n_idx       = '0;
                    n_scan_addr = r_rp;
                    unique case (t_op'(i_req.operation))
                        OP_ENQ: begin
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we = 1'b1;
                                n_wp     = ptr_next(r_wp);
                                n_count  = r_count + CNT_W'(1);
                            end
                            n_state = S_DONE;
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // Oldest word arrives from memory
            S_READ: begin
                n_item = i_mem_rdata;
                if (r_op == OP_DEQ) begin
                    n_rp    = ptr_next(r_rp);
                    n_count = r_count - CNT_W'(1);
                end
                n_state = S_DONE;
            end
            // One entry compared per cycle, oldest first
            S_SCAN: begin
                if (i_mem_rdata == r_key) begin
                    n_pos   = r_idx;
                    n_state = S_DONE;
                end else if (CNT_W'(r_idx) == r_count - CNT_W'(1)) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx       = r_idx + PTR_W'(1);
                    n_scan_addr = ptr_next(r_scan_addr);
                end
            end
            // Hand the result to the response register once it is free
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_item   = r_item;
                    n_out_pos    = POS_W'(r_pos);
                    n_out_occ    = OCC_W'(r_count);
                    n_out_empty  = (r_count == '0);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_mem_waddr = r_wp;
    assign o_mem_wdata = i_req.value;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_status     <= n_status;
        r_item       <= n_item;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_scan_addr  <= n_scan_addr;
        r_out_status <= n_out_status;
        r_out_item   <= n_out_item;
        r_out_pos    <= n_out_pos;
        r_out_occ    <= n_out_occ;
        r_out_empty  <= n_out_empty;
    end

    // Channel outputs
    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.item      = r_out_item;
    assign o_rsp.position  = r_out_pos;
    assign o_rsp.occupancy = r_out_occ;
    assign o_rsp.is_empty  = r_out_empty;

endmodule

@@ hdl/fifo_queue_with_search_top.sv @@
`timescale 1ns / 1ps
// Top level of the FIFO queue with linear search.
// Depends on fqs_pkg, fqs_if, fqs_ram and fqs_ctrl.
// Usage:
//   i_req carries one operation per transfer (enqueue, dequeue, peek, search)
//   with a 32-bit value; o_rsp returns exactly one result per request with
//   status, item, search position, occupancy and empty flag. Requests are
//   handled one at a time; i_req.ready is high while the sequencer is idle.
// Sequence (request transfer to result registered):
//   Enqueue, or any refused operation: straight to the result state.
//   Dequeue and peek: one memory read, then the result state.
//   Search: k = entries compared (1..DEPTH), one per cycle, oldest first,
//   through the single read port of the entry memory, then the result state.
//   i_req.ready returns as the result is registered, so a request is taken
//   only once the previous one is through.
// Reset:
//   Synchronous active-low reset empties the queue and drops any pending
//   result; entry storage is not cleared and is only read where occupied.
// Back-pressure:
//   A result waits in the output register while o_rsp.ready is low; the
//   sequencer accepts one further request meanwhile and holds its result.
module fifo_queue_with_search_top import fqs_pkg::*; #(
    parameter int DEPTH = FQS_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fqs_in_if.sink    i_req,
    fqs_out_if.source o_rsp
);

    localparam int PTR_W = $clog2(DEPTH);

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [PTR_W-1:0] mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    // Sequencer
    fqs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // Entry storage
    fqs_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

@@ hdl/fqs_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the queue top level, attached by bind.
// Depends on fqs_pkg and fifo_queue_with_search_top.
module fqs_checker import fqs_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [ST_W-1:0]  i_rsp_status,
    input logic [VAL_W-1:0] i_rsp_item,
    input logic [POS_W-1:0] i_rsp_position
);

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_item)
            && $stable(i_rsp_position))
        else $error("stalled response changed");

    // Only one request in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while previous one in work");

    // Item and position are zero unless the operation succeeded
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != ST_OK) |->
            (i_rsp_item == '0) && (i_rsp_position == '0))
        else $error("nonzero item or position on failed operation");

    // Reset drops the response
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind fifo_queue_with_search_top fqs_checker u_fqs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_item     (o_rsp.item),
    .i_rsp_position (o_rsp.position)
);

@@ tb/fifo_queue_with_search_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for fifo_queue_with_search_top: directed table, fill/drain, random op mixes.
// Ring-queue model or typed row checks each response. Depends on fqs_pkg, fqs_if, RTL.
module fifo_queue_with_search_top_tb;
    import fqs_pkg::*;

    localparam int DEPTH        = FQS_DEPTH;
    localparam int RANDOM_ITEMS = 700;
    localparam int BLOCK_ITEMS  = 50;
    localparam int QUIET_BLOCKS = 3;    // trailing blocks run without idling
    localparam int TAIL_CYCLES  = 40;   // longer than a full-depth search
    localparam logic [VAL_W-1:0] MARK_WORD = 32'h1357_9BDF;

    typedef struct packed {
        t_status           status;
        logic [VAL_W-1:0]  item;
        logic [POS_W-1:0]  position;
        logic [OCC_W-1:0]  occupancy;
        logic              is_empty;
    } t_rsp;

    typedef struct packed {
        t_op               op;
        logic [VAL_W-1:0]  value;
        logic              known;   // expected response typed in below
        t_rsp              rsp;
    } t_stim_row;

    localparam t_rsp NO_RSP = '0;

    // Directed rows: empty queue, field extremes, duplicates, first-match search
    localparam int DIRECTED_N = 25;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_N] = '{
        '{OP_PEEK,   32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 4'd0, 5'd0, 1'b1}},
        '{OP_DEQ,    32'hFFFF_FFFF, 1'b1, '{ST_EMPTY,    32'h0000_0000, 4'd0, 5'd0, 1'b1}},
        '{OP_SEARCH, 32'h0000_0000, 1'b1, '{ST_NOTFOUND, 32'h0000_0000, 4'd0, 5'd0, 1'b1}},
        '{OP_ENQ,    32'h8000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 4'd0, 5'd1, 1'b0}},
        '{OP_ENQ,    32'h7FFF_FFFF, 1'b1, '{ST_OK,       32'h0000_0000, 4'd0, 5'd2, 1'b0}},
        '{OP_ENQ,    32'hFFFF_FFFF, 1'b1, '{ST_OK,       32'h0000_0000, 4'd0, 5'd3, 1'b0}},
        '{OP_ENQ,    32'h0000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 4'd0, 5'd4, 1'b0}},
        '{OP_ENQ,    32'h7FFF_FFFF, 1'b1, '{ST_OK,       32'h0000_0000, 4'd0, 5'd5, 1'b0}},
        '{OP_SEARCH, 32'h7FFF_FFFF, 1'b1, '{ST_OK,       32'h0000_0000, 4'd1, 5'd5, 1'b0}},
        '{OP_SEARCH, 32'h0000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 4'd3, 5'd5, 1'b0}},
        '{OP_SEARCH, 32'h1234_5678, 1'b1, '{ST_NOTFOUND, 32'h0000_0000, 4'd0, 5'd5, 1'b0}},
        '{OP_SEARCH, 32'h8000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 4'd0, 5'd5, 1'b0}},
        '{OP_PEEK,   32'h0000_0000, 1'b1, '{ST_OK,       32'h8000_0000, 4'd0, 5'd5, 1'b0}},
        '{OP_DEQ,    32'h0000_0000, 1'b1, '{ST_OK,       32'h8000_0000, 4'd0, 5'd4, 1'b0}},
        '{OP_SEARCH, 32'h8000_0000, 1'b1, '{ST_NOTFOUND, 32'h0000_0000, 4'd0, 5'd4, 1'b0}},
        '{OP_DEQ,    32'h0000_0000, 1'b1, '{ST_OK,       32'h7FFF_FFFF, 4'd0, 5'd3, 1'b0}},
        '{OP_DEQ,    32'h0000_0000, 1'b1, '{ST_OK,       32'hFFFF_FFFF, 4'd0, 5'd2, 1'b0}},
        '{OP_DEQ,    32'h0000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 4'd0, 5'd1, 1'b0}},
        '{OP_DEQ,    32'h0000_0000, 1'b1, '{ST_OK,       32'h7FFF_FFFF, 4'd0, 5'd0, 1'b1}},
        '{OP_DEQ,    32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 4'd0, 5'd0, 1'b1}},
        '{OP_ENQ,    32'hA5A5_A5A5, 1'b0, NO_RSP},
        '{OP_PEEK,   32'h0000_0000, 1'b0, NO_RSP},
        '{OP_SEARCH, 32'h5A5A_5A5A, 1'b0, NO_RSP},
        '{OP_ENQ,    32'h5A5A_5A5A, 1'b0, NO_RSP},
        '{OP_SEARCH, 32'h5A5A_5A5A, 1'b0, NO_RSP}
    };

    logic i_clk;
    logic i_rst_n;

    fqs_in_if  req_if ();
    fqs_out_if rsp_if ();

    fifo_queue_with_search_top #(
        .DEPTH (DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Predictor state: ring contents, pointers and fill level
    logic [VAL_W-1:0] ring_slot [DEPTH];
    int unsigned      ring_rd;
    int unsigned      ring_wr;
    int unsigned      ring_count;

    t_rsp expected_rsp_q [$];
    int   mismatch_count;
    bit   sender_idle_on;
    bit   sink_idle_on;

    // Apply one operation to the ring and return the response it produces
    function automatic t_rsp queue_model_apply(input t_op op, input logic [VAL_W-1:0] val);
        t_rsp        r;
        int unsigned p;
        r = NO_RSP;
        r.status = ST_OK;
        case (op)
            OP_ENQ: begin
                if (ring_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_slot[ring_wr] = val;
                    ring_wr = (ring_wr + 1) % DEPTH;
                    ring_count++;
                end
            end
            OP_DEQ, OP_PEEK: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.item = ring_slot[ring_rd];
                    if (op == OP_DEQ) begin
                        ring_rd = (ring_rd + 1) % DEPTH;
                        ring_count--;
                    end
                end
            end
            default: begin
                // linear scan from the oldest entry; first match wins
                r.status = ST_NOTFOUND;
                p = ring_rd;
                for (int i = 0; i < ring_count; i++) begin
                    if (ring_slot[p] == val) begin
                        r.status   = ST_OK;
                        r.position = i[POS_W-1:0];
                        break;
                    end
                    p = (p + 1) % DEPTH;
                end
            end
        endcase
        r.occupancy = ring_count[OCC_W-1:0];
        r.is_empty  = (ring_count == 0);
        return r;
    endfunction

    // Word mix: extremes, a small pool that forces duplicates, and full-range noise
    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // Present one request, wait for its transfer, record the expected response
    task automatic send_op(input t_op op, input logic [VAL_W-1:0] val,
                           input logic known, input t_rsp typed);
        t_rsp predicted;
        int   gap;
        if (sender_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= val;
        do @(negedge i_clk); while (!req_if.ready);
        @(posedge i_clk);
        predicted = queue_model_apply(op, val);
        expected_rsp_q.push_back(known ? typed : predicted);
    endtask

    // Drop valid and hold off until every outstanding response is back
    task automatic hold_until_drained();
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Response back-pressure in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Response checker: a transfer is sampled mid-cycle, ahead of the edge that takes it
    always @(negedge i_clk) begin : check_rsp
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsp_q.size() == 0) begin
                $error("response with no request outstanding: status %0d item %0d",
                       rsp_if.status, $signed(rsp_if.item));
                mismatch_count++;
            end else begin
                want = expected_rsp_q.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    mismatch_count++;
                end
                if (rsp_if.item !== want.item) begin
                    $error("item: expected %0d, got %0d", $signed(want.item),
                           $signed(rsp_if.item));
                    mismatch_count++;
                end
                if (rsp_if.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position,
                           rsp_if.position);
                    mismatch_count++;
                end
                if (rsp_if.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy,
                           rsp_if.occupancy);
                    mismatch_count++;
                end
                if (rsp_if.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty,
                           rsp_if.is_empty);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        t_op              op;
        logic [VAL_W-1:0] val;
        int               enq_pct;

        mismatch_count   = 0;
        ring_rd          = 0;
        ring_wr          = 0;
        ring_count       = 0;
        sender_idle_on   = 1'b1;
        sink_idle_on     = 1'b1;
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.operation <= OP_ENQ;
        req_if.value     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < DIRECTED_N; i++) begin
            send_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value,
                    DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].rsp);
        end
        hold_until_drained();

        // Fill to the brim, refuse twice, find the newest entry at the far end, drain
        while (ring_count < DEPTH - 1) send_op(OP_ENQ, rand_word(), 1'b0, NO_RSP);
        send_op(OP_ENQ, MARK_WORD, 1'b0, NO_RSP);
        send_op(OP_ENQ, rand_word(), 1'b0, NO_RSP);
        send_op(OP_ENQ, MARK_WORD, 1'b0, NO_RSP);
        send_op(OP_SEARCH, MARK_WORD, 1'b0, NO_RSP);
        send_op(OP_PEEK, rand_word(), 1'b0, NO_RSP);
        while (ring_count > 0) send_op(OP_DEQ, rand_word(), 1'b0, NO_RSP);
        send_op(OP_SEARCH, MARK_WORD, 1'b0, NO_RSP);

        // Random blocks, each with its own enqueue bias so fill level wanders
        for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
            sender_idle_on = (blk < RANDOM_ITEMS / BLOCK_ITEMS - QUIET_BLOCKS)
                             && ($urandom_range(0, 3) != 0);
            sink_idle_on   = (blk < RANDOM_ITEMS / BLOCK_ITEMS - QUIET_BLOCKS)
                             && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0:       enq_pct = 75;
                1:       enq_pct = 50;
                default: enq_pct = 25;
            endcase
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                if ($urandom_range(0, 99) < enq_pct) begin
                    op = OP_ENQ;
                end else begin
                    case ($urandom_range(0, 2))
                        0:       op = OP_DEQ;
                        1:       op = OP_PEEK;
                        default: op = OP_SEARCH;
                    endcase
                end
                // searches mostly target a word that is held
                if (op == OP_SEARCH && ring_count > 0 && $urandom_range(0, 9) < 6) begin
                    val = ring_slot[(ring_rd + $urandom_range(0, ring_count - 1)) % DEPTH];
                end else begin
                    val = rand_word();
                end
                send_op(op, val, 1'b0, NO_RSP);
            end
            if (blk == 6) hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
